[rtl/loh_pkg.sv]
// Shared types, constants and helper functions for the label overlap histogram.
package loh_pkg;

    localparam int LABEL_COUNT = 16384;
    localparam int COUNT_WIDTH = 32;
    localparam int MAX_LABEL   = 14999;
    localparam int LABEL_W     = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
    localparam int LAB_LIMIT   = (MAX_LABEL < LABEL_COUNT - 1) ? MAX_LABEL : LABEL_COUNT - 1;
    localparam int CMP_W       = 17;
    localparam int SUM_W       = COUNT_WIDTH + 1;
    localparam int OUT_W       = 32;
    localparam int EXT_W       = OUT_W + COUNT_WIDTH;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 7 * OUT_W;
    localparam int OUT_USER_W  = 1;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [LABEL_W-1:0]     idx_t;
    typedef logic [OUT_W-1:0]       out_word_t;

    localparam cnt_t      CNT_MAX = '1;
    localparam out_word_t OUT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_VOXEL = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        OP_VOXEL,
        OP_SKIP,
        OP_READ,
        OP_WRITE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_UNION
    } back_state_t;

    typedef struct packed {
        op_t  op;
        idx_t idx_a;
        idx_t idx_b;
        logic same;
        idx_t tab_idx;
        logic tab_ok;
        logic flag;
    } queue_item_t;

    typedef struct packed {
        logic      skipped;
        out_word_t count_first;
        out_word_t count_second;
        out_word_t count_overlap;
        out_word_t count_union;
        out_word_t total_first;
        out_word_t total_second;
        out_word_t total_overlap;
    } result_t;

    function automatic cnt_t sat_inc(cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

    function automatic out_word_t clip_out(cnt_t v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return ext[OUT_W-1:0];
    endfunction

endpackage

[rtl/loh_front.sv]
// Input side: accepts transactions, checks label ranges and classifies each item.
module loh_front import loh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  q_full,
    input  logic                  clearing,
    output logic                  q_push,
    output queue_item_t           q_item
);

    logic [15:0]      first_label;
    logic [15:0]      second_label;
    logic [13:0]      table_label;
    logic             member_flag;
    logic [CMP_W-1:0] first_u;
    logic [CMP_W-1:0] second_u;
    logic             a_ok;
    logic             b_ok;
    logic             ready_reg;

    assign first_label  = s_tdata[15:0];
    assign second_label = s_tdata[31:16];
    assign table_label  = s_tdata[45:32];
    assign member_flag  = s_tdata[46];

    assign first_u  = {1'b0, first_label};
    assign second_u = {1'b0, second_label};
    assign a_ok = !first_label[15] && (first_u <= CMP_W'(LAB_LIMIT));
    assign b_ok = !second_label[15] && (second_u <= CMP_W'(LAB_LIMIT));

    // Hold off while the counter stores are swept after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else begin
            ready_reg <= !clearing;
        end
    end

    assign s_tready = ready_reg && !clearing && !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.idx_a   = first_label[LABEL_W-1:0];
        q_item.idx_b   = second_label[LABEL_W-1:0];
        q_item.same    = (first_label[LABEL_W-1:0] == second_label[LABEL_W-1:0]);
        q_item.tab_idx = LABEL_W'(table_label);
        q_item.tab_ok  = (CMP_W'(table_label) < CMP_W'(LABEL_COUNT));
        q_item.flag    = member_flag;
        case (s_tuser)
            MODE_VOXEL: q_item.op = (a_ok && b_ok) ? OP_VOXEL : OP_SKIP;
            MODE_READ:  q_item.op = OP_READ;
            MODE_WRITE: q_item.op = OP_WRITE;
            default:    q_item.op = OP_NOP;
        endcase
    end

endmodule

[rtl/loh_queue.sv]
// Short first-in first-out queue between the classifying front and the execution back.
module loh_queue import loh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  queue_item_t push_item,
    input  logic        pop,
    output queue_item_t head,
    output logic        empty,
    output logic        full
);

    queue_item_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/loh_back.sv]
// Execution side: counter memories, membership map, totals and the result register.
module loh_back import loh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  queue_item_t q_head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        clearing,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_result
);

    cnt_t first_mem   [LABEL_COUNT];
    cnt_t second_mem  [LABEL_COUNT];
    cnt_t overlap_mem [LABEL_COUNT];
    logic member_mem  [LABEL_COUNT];

    back_state_t      state_reg;
    back_state_t      state_next;
    idx_t             clr_cnt_reg;
    idx_t             clr_cnt_next;
    queue_item_t      cur_reg;
    queue_item_t      cur_next;
    logic             count_all_reg;
    cnt_t             sum_first_reg;
    cnt_t             sum_first_next;
    cnt_t             sum_second_reg;
    cnt_t             sum_second_next;
    cnt_t             sum_overlap_reg;
    cnt_t             sum_overlap_next;
    logic [SUM_W-1:0] fs_reg;
    logic [SUM_W-1:0] fs_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;

    cnt_t             first_rd_reg;
    cnt_t             second_rd_reg;
    cnt_t             overlap_rd_reg;
    logic             member_a_rd_reg;
    logic             member_b_rd_reg;

    idx_t             rd_addr_a;
    idx_t             rd_addr_b;
    logic             first_we;
    logic             second_we;
    logic             overlap_we;
    logic             member_we;
    idx_t             first_wa;
    idx_t             second_wa;
    idx_t             overlap_wa;
    idx_t             member_wa;
    cnt_t             first_wd;
    cnt_t             second_wd;
    cnt_t             overlap_wd;
    logic             member_wd;
    logic             ca;
    logic             cb;
    logic [SUM_W-1:0] diff;
    cnt_t             union_cnt;

    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign rd_addr_a = (q_head.op == OP_VOXEL) ? q_head.idx_a : q_head.tab_idx;
    assign rd_addr_b = (q_head.op == OP_VOXEL) ? q_head.idx_b : q_head.tab_idx;

    assign ca = count_all_reg || member_a_rd_reg;
    assign cb = count_all_reg || member_b_rd_reg;

    assign diff = (fs_reg >= SUM_W'(overlap_rd_reg)) ? fs_reg - SUM_W'(overlap_rd_reg) : '0;
    assign union_cnt = (diff > SUM_W'(CNT_MAX)) ? CNT_MAX : diff[COUNT_WIDTH-1:0];

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_next         = cur_reg;
        sum_first_next   = sum_first_reg;
        sum_second_next  = sum_second_reg;
        sum_overlap_next = sum_overlap_reg;
        fs_next          = fs_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        q_pop            = 1'b0;
        first_we         = 1'b0;
        second_we        = 1'b0;
        overlap_we       = 1'b0;
        member_we        = 1'b0;
        first_wa         = cur_reg.idx_a;
        second_wa        = cur_reg.idx_b;
        overlap_wa       = cur_reg.idx_a;
        member_wa        = cur_reg.tab_idx;
        first_wd         = sat_inc(first_rd_reg);
        second_wd        = sat_inc(second_rd_reg);
        overlap_wd       = sat_inc(overlap_rd_reg);
        member_wd        = cur_reg.flag;
        case (state_reg)
            ST_CLEAR: begin
                first_we     = 1'b1;
                second_we    = 1'b1;
                overlap_we   = 1'b1;
                member_we    = 1'b1;
                first_wa     = clr_cnt_reg;
                second_wa    = clr_cnt_reg;
                overlap_wa   = clr_cnt_reg;
                member_wa    = clr_cnt_reg;
                first_wd     = '0;
                second_wd    = '0;
                overlap_wd   = '0;
                member_wd    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LABEL_W'(LABEL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Take the next item only when the result slot is free or freeing.
                if (!q_empty && (!out_valid_reg || out_ready)) begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                out_next = '0;
                case (cur_reg.op)
                    OP_VOXEL: begin
                        first_we  = 1'b1;
                        second_we = 1'b1;
                        if (cur_reg.same) begin
                            overlap_we = 1'b1;
                            if (ca) begin
                                sum_overlap_next = sat_inc(sum_overlap_reg);
                            end
                        end
                        if (ca) begin
                            sum_first_next = sat_inc(sum_first_reg);
                        end
                        if (cb) begin
                            sum_second_next = sat_inc(sum_second_reg);
                        end
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    OP_SKIP: begin
                        out_next.skipped = 1'b1;
                        out_valid_next   = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    OP_WRITE: begin
                        member_we      = cur_reg.tab_ok;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    OP_READ: begin
                        fs_next    = SUM_W'(first_rd_reg) + SUM_W'(second_rd_reg);
                        state_next = ST_UNION;
                    end
                    default: begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                endcase
            end
            ST_UNION: begin
                out_next               = '0;
                out_next.total_first   = clip_out(sum_first_reg);
                out_next.total_second  = clip_out(sum_second_reg);
                out_next.total_overlap = clip_out(sum_overlap_reg);
                if (cur_reg.tab_ok) begin
                    out_next.count_first   = clip_out(first_rd_reg);
                    out_next.count_second  = clip_out(second_rd_reg);
                    out_next.count_overlap = clip_out(overlap_rd_reg);
                    out_next.count_union   = clip_out(union_cnt);
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            count_all_reg   <= 1'b0;
            sum_first_reg   <= '0;
            sum_second_reg  <= '0;
            sum_overlap_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            sum_first_reg   <= sum_first_next;
            sum_second_reg  <= sum_second_next;
            sum_overlap_reg <= sum_overlap_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en) begin
                count_all_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        fs_reg  <= fs_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (first_we) begin
            first_mem[first_wa] <= first_wd;
        end
        if (q_pop) begin
            first_rd_reg <= first_mem[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (second_we) begin
            second_mem[second_wa] <= second_wd;
        end
        if (q_pop) begin
            second_rd_reg <= second_mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (overlap_we) begin
            overlap_mem[overlap_wa] <= overlap_wd;
        end
        if (q_pop) begin
            overlap_rd_reg <= overlap_mem[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (member_we) begin
            member_mem[member_wa] <= member_wd;
        end
        if (q_pop) begin
            member_a_rd_reg <= member_mem[rd_addr_a];
            member_b_rd_reg <= member_mem[rd_addr_b];
        end
    end

endmodule

[rtl/label_overlap_histogram_unit.sv]
// Top level of the label overlap histogram unit.
//
// Label overlap histogram. Each input transaction carries a mode in s_tuser and a
// pair of labels, a table label and a membership flag in s_tdata. Mode 0 counts one
// voxel: the first-volume count of the first label, the second-volume count of the
// second label and, when both labels agree, the overlap count go up by one, and the
// three overall totals follow either for every voxel (count_all set) or only for
// labels marked in the membership map. A voxel with either label negative or above
// 14999 is skipped whole and reported with skipped set. Mode 1 returns the counts of
// table_label, their union (first plus second minus overlap) and the totals. Mode 2
// writes one membership bit. Every counter saturates. Each transaction returns
// exactly one result transaction; unused fields read as zero. Timing: after reset
// the three counter memories and the membership map are swept to zero, one entry a
// cycle, so s_tready stays low until the sweep is done. After that a mode 0, 2 or
// 3 item passes through the execution side as a read step on the single-port
// counter memories, then a read-modify-write step; a mode 1 item also takes a
// union step. A four-entry queue behind the input lets new items be accepted
// while an earlier result waits in the output register.
module label_overlap_histogram_unit import loh_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration: count_all
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    // input channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first_label[15:0], second_label[31:16], table_label[45:32],
    // member_flag[46], zero[47]
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  logic [IN_USER_W-1:0]   s_tuser,
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // count_first[31:0], count_second[63:32], count_overlap[95:64],
    // count_union[127:96], total_first[159:128], total_second[191:160],
    // total_overlap[223:192]
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // skipped[0]
    output logic [OUT_USER_W-1:0]  m_tuser
);

    queue_item_t push_item;
    queue_item_t head_item;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    logic        clearing;
    result_t     result;

    // Classify incoming transactions and push them into the queue.
    loh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .clearing (clearing),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decouple acceptance from execution.
    loh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Carry out each item against the memories and hold its result.
    loh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_head      (head_item),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // Pack the result, first field in the lowest bits.
    assign m_tuser = result.skipped;
    assign m_tdata = {result.total_overlap, result.total_second, result.total_first,
                      result.count_union, result.count_overlap, result.count_second,
                      result.count_first};

endmodule

[rtl/loh_checker.sv]
// Port-level checks for the label overlap histogram unit, bound to the top level.
module loh_checker import loh_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    logic [OUT_W-1:0] c_first;
    logic [OUT_W-1:0] c_second;
    logic [OUT_W-1:0] c_overlap;
    logic [OUT_W-1:0] c_union;
    logic [OUT_W-1:0] t_first;
    logic [OUT_W-1:0] t_overlap;

    assign c_first   = m_tdata[31:0];
    assign c_second  = m_tdata[63:32];
    assign c_overlap = m_tdata[95:64];
    assign c_union   = m_tdata[127:96];
    assign t_first   = m_tdata[159:128];
    assign t_overlap = m_tdata[223:192];

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset starts the clearing sweep: no input taken, no result shown.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("transaction possible straight after reset");

    // A skipped voxel carries no counts.
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("skipped result with nonzero data");

    // Overlap never exceeds either per-label count, union covers both.
    a_label: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> c_overlap <= c_first && c_overlap <= c_second &&
                     c_union >= c_first && c_union >= c_second)
        else $error("inconsistent per-label counts");

    // The overlap total never passes the first-volume total.
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> t_overlap <= t_first)
        else $error("overlap total above first total");

endmodule

bind label_overlap_histogram_unit loh_checker u_loh_checker (.*);
